FILE: design/i2cm_pkg.sv
// Shared types, command codes and bus timing constants for the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

    // Engine phases: idle, or a wait, a poll or a sample between two line changes
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_STOP_A    = 4'd3,
        PH_STOP_B    = 4'd4,
        PH_WA_A      = 4'd5,
        PH_WA_B      = 4'd6,
        PH_WA_POLL   = 4'd7,
        PH_WR_SETUP  = 4'd8,
        PH_WR_HIGH   = 4'd9,
        PH_WR_TAIL   = 4'd10,
        PH_RD_SETTLE = 4'd11,
        PH_RD_LOW    = 4'd12,
        PH_RD_HIGH   = 4'd13,
        PH_ACK_LOW   = 4'd14,
        PH_ACK_HIGH  = 4'd15
    } phase_t;

    // Command codes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_STOP     = 3'd2;
    localparam logic [2:0] ACT_WRITE    = 3'd3;
    localparam logic [2:0] ACT_WAIT_ACK = 3'd4;
    localparam logic [2:0] ACT_READ     = 3'd5;

    // Configuration register indexes
    localparam logic REG_TICKS_PER_US = 1'b0;
    localparam logic REG_POLL_LIMIT   = 1'b1;

    localparam logic [9:0] TICKS_PER_US_RESET = 10'd16;
    localparam logic [7:0] POLL_LIMIT_RESET   = 8'd250;

    // Bus waits in microseconds
    localparam logic [3:0] DLY_START_US  = 4'd4;
    localparam logic [3:0] DLY_BIT_US    = 4'd2;
    localparam logic [3:0] DLY_ACK_US    = 4'd1;
    localparam logic [3:0] DLY_SETTLE_US = 4'd10;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // One input beat
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_data;
        logic       ack_level;
        logic       sda_in;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } res_beat_t;

    // Engine state carried from tick to tick
    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_index;
        logic [7:0] shift_byte;
        logic [3:0] delay_left;
        logic [9:0] prescale_count;
        logic [7:0] poll_count;
        logic       scl;
        logic       sda;
        logic       drv;
        logic [7:0] last_read;
        logic       fail_flag;
        logic       ack_hold;
    } eng_state_t;

    localparam eng_state_t ENG_RESET = '{
        phase:          PH_IDLE,
        bit_index:      4'd0,
        shift_byte:     8'd0,
        delay_left:     4'd0,
        prescale_count: 10'd0,
        poll_count:     8'd0,
        scl:            1'b1,
        sda:            1'b1,
        drv:            1'b1,
        last_read:      8'd0,
        fail_flag:      1'b0,
        ack_hold:       1'b0
    };

endpackage

`default_nettype wire

FILE: design/i2cm_step.sv
// Next-state and result logic for one tick of the I2C master bit engine.
`default_nettype none

module i2cm_step
    import i2cm_pkg::*;
(
    input  eng_state_t cur,
    input  in_beat_t   beat,
    input  logic [9:0] ticks_per_us,
    input  logic [7:0] poll_limit,
    output eng_state_t nxt,
    output res_beat_t  res
);

    // Arm a wait of the given length and move on to the given phase
    function automatic eng_state_t load_delay(eng_state_t s, logic [3:0] us, phase_t ph);
        eng_state_t r;
        r                = s;
        r.delay_left     = us;
        r.prescale_count = 10'd0;
        r.phase          = ph;
        return r;
    endfunction

    // Drive both lines low and enter the stop sequence
    function automatic eng_state_t begin_stop(eng_state_t s);
        eng_state_t r;
        r     = s;
        r.drv = 1'b1;
        r.scl = 1'b0;
        r.sda = 1'b0;
        return load_delay(r, DLY_START_US, PH_STOP_A);
    endfunction

    logic [10:0] prescale_inc;
    logic        done;

    assign prescale_inc = {1'b0, cur.prescale_count} + 11'd1;

    // Advance the engine by one tick
    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        case (cur.phase)
            PH_IDLE:
            begin
                case (beat.action)
                    ACT_START:
                    begin
                        nxt.scl = 1'b1;
                        nxt.sda = 1'b1;
                        nxt.drv = 1'b1;
                        nxt     = load_delay(nxt, DLY_START_US, PH_START_A);
                    end
                    ACT_STOP:
                        nxt = begin_stop(nxt);
                    ACT_WRITE:
                    begin
                        nxt.shift_byte = beat.write_data;
                        nxt.bit_index  = 4'd0;
                        nxt.drv        = 1'b1;
                        nxt.scl        = 1'b0;
                        nxt.sda        = beat.write_data[7];
                        nxt            = load_delay(nxt, DLY_BIT_US, PH_WR_SETUP);
                    end
                    ACT_WAIT_ACK:
                    begin
                        nxt.sda = 1'b1;
                        nxt.drv = 1'b0;
                        nxt     = load_delay(nxt, DLY_ACK_US, PH_WA_A);
                    end
                    ACT_READ:
                    begin
                        nxt.drv        = 1'b0;
                        nxt.ack_hold   = beat.ack_level;
                        nxt.shift_byte = 8'd0;
                        nxt.bit_index  = 4'd0;
                        nxt            = load_delay(nxt, DLY_SETTLE_US, PH_RD_SETTLE);
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Poll SDA once per tick for the acknowledge
            PH_WA_POLL:
            begin
                if (!beat.sda_in)
                begin
                    nxt.scl       = 1'b0;
                    nxt.fail_flag = 1'b0;
                    nxt.phase     = PH_IDLE;
                    done          = 1'b1;
                end
                else if (cur.poll_count >= poll_limit)
                begin
                    nxt.fail_flag = 1'b1;
                    nxt           = begin_stop(nxt);
                end
                else
                begin
                    nxt.poll_count = cur.poll_count + 8'd1;
                end
            end

            // Sample one read bit while SCL is high
            PH_RD_HIGH:
            begin
                nxt.shift_byte = {cur.shift_byte[6:0], beat.sda_in};
                nxt.bit_index  = cur.bit_index + 4'd1;
                nxt.scl        = 1'b0;
                if (nxt.bit_index >= BITS_PER_BYTE)
                begin
                    nxt.last_read = nxt.shift_byte;
                    nxt.drv       = 1'b1;
                    nxt.sda       = cur.ack_hold;
                    nxt           = load_delay(nxt, DLY_BIT_US, PH_ACK_LOW);
                end
                else
                begin
                    nxt = load_delay(nxt, DLY_BIT_US, PH_RD_LOW);
                end
            end

            // Count down the current wait, then take the next step
            default:
            begin
                if (prescale_inc >= {1'b0, ticks_per_us})
                begin
                    nxt.prescale_count = 10'd0;
                    if (cur.delay_left != 4'd0)
                    begin
                        nxt.delay_left = cur.delay_left - 4'd1;
                    end
                end
                else
                begin
                    nxt.prescale_count = prescale_inc[9:0];
                end

                if (nxt.delay_left == 4'd0)
                begin
                    case (cur.phase)
                        PH_START_A:
                        begin
                            nxt.sda = 1'b0;
                            nxt     = load_delay(nxt, DLY_START_US, PH_START_B);
                        end
                        PH_START_B:
                        begin
                            nxt.scl   = 1'b0;
                            nxt.phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        PH_STOP_A:
                        begin
                            nxt.scl = 1'b1;
                            nxt.sda = 1'b1;
                            nxt     = load_delay(nxt, DLY_START_US, PH_STOP_B);
                        end
                        PH_STOP_B:
                        begin
                            nxt.phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        PH_WA_A:
                        begin
                            nxt.scl = 1'b1;
                            nxt     = load_delay(nxt, DLY_ACK_US, PH_WA_B);
                        end
                        PH_WA_B:
                        begin
                            nxt.poll_count = 8'd0;
                            nxt.phase      = PH_WA_POLL;
                        end
                        PH_WR_SETUP:
                        begin
                            nxt.scl = 1'b1;
                            nxt     = load_delay(nxt, DLY_BIT_US, PH_WR_HIGH);
                        end
                        PH_WR_HIGH:
                        begin
                            nxt.scl = 1'b0;
                            nxt     = load_delay(nxt, DLY_BIT_US, PH_WR_TAIL);
                        end
                        PH_WR_TAIL:
                        begin
                            nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                            nxt.bit_index  = cur.bit_index + 4'd1;
                            if (nxt.bit_index >= BITS_PER_BYTE)
                            begin
                                nxt.phase = PH_IDLE;
                                done      = 1'b1;
                            end
                            else
                            begin
                                nxt.sda = nxt.shift_byte[7];
                                nxt     = load_delay(nxt, DLY_BIT_US, PH_WR_SETUP);
                            end
                        end
                        PH_RD_SETTLE:
                        begin
                            nxt.scl = 1'b0;
                            nxt     = load_delay(nxt, DLY_BIT_US, PH_RD_LOW);
                        end
                        PH_RD_LOW:
                        begin
                            nxt.scl   = 1'b1;
                            nxt.phase = PH_RD_HIGH;
                        end
                        PH_ACK_LOW:
                        begin
                            nxt.scl = 1'b1;
                            nxt     = load_delay(nxt, DLY_BIT_US, PH_ACK_HIGH);
                        end
                        PH_ACK_HIGH:
                        begin
                            nxt.scl   = 1'b0;
                            nxt.phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        default:
                            nxt.phase = PH_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Form the result beat from the updated state
    always_comb
    begin
        res.scl_out    = nxt.scl;
        res.sda_out    = nxt.sda;
        res.sda_drive  = nxt.drv;
        res.busy_res   = (nxt.phase != PH_IDLE);
        res.done_res   = done;
        res.read_data  = nxt.last_read;
        res.ack_failed = nxt.fail_flag;
    end

endmodule

`default_nettype wire

FILE: design/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: input register, engine state, result register.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------------------
//  s_*     | in        | tvalid / tready  | one clock tick: command, byte, ack, SDA
//  m_*     | out       | tvalid / tready  | line levels and status after that tick
//  cfg_*   | in        | cfg_we only      | ticks per microsecond, ack poll limit
//
// Each beat is held in the input register; the step logic then updates the
// engine state and loads the result register in the same edge, so one beat per cycle
// flows through while m_tready does not stall. Reset brings the engine to idle with
// SCL and SDA high and driven. A stalled m_tready holds the result register and then
// the input register; s_tready drops only when both are full.
`default_nettype none

module i2c_master_bit_engine_core
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [2:0] action, [10:3] write_data, [11] ack_level, [12] sda_in, [15:13] zero
    input  wire logic [15:0] s_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] read_data, [13] ack_failed, [15:14] zero
    output      logic [15:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_data
);

    logic       in_valid_reg;
    in_beat_t   in_beat_reg;
    logic       out_valid_reg;
    res_beat_t  out_beat_reg;
    eng_state_t state_reg;
    eng_state_t state_next;
    res_beat_t  res_next;
    logic [9:0] ticks_per_us_reg;
    logic [7:0] poll_limit_reg;
    logic       advance;
    in_beat_t   s_beat;

    // Unpack the input beat
    assign s_beat.action     = s_tdata[2:0];
    assign s_beat.write_data = s_tdata[10:3];
    assign s_beat.ack_level  = s_tdata[11];
    assign s_beat.sda_in     = s_tdata[12];

    // Process the held beat whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg <= TICKS_PER_US_RESET;
            poll_limit_reg   <= POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICKS_PER_US: ticks_per_us_reg <= cfg_data;
                REG_POLL_LIMIT:   poll_limit_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_beat_reg <= s_beat;
        end
    end

    i2cm_step u_step (
        .cur          (state_reg),
        .beat         (in_beat_reg),
        .ticks_per_us (ticks_per_us_reg),
        .poll_limit   (poll_limit_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    // Engine state: advance once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_beat_reg <= res_next;
        end
    end

    // Pack the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_beat_reg.ack_failed, out_beat_reg.read_data,
                       out_beat_reg.done_res, out_beat_reg.busy_res,
                       out_beat_reg.sda_drive, out_beat_reg.sda_out,
                       out_beat_reg.scl_out};

    // A completed command always leaves the engine idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.done_res |-> !out_beat_reg.busy_res)
        else $error("done reported while still busy");

    // Poll and sample phases are only entered with an expired wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_WA_POLL || state_reg.phase == PH_RD_HIGH)
            |-> state_reg.delay_left == 4'd0)
        else $error("poll phase entered with a wait pending");

    // Bit counter never runs past one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_index <= BITS_PER_BYTE)
        else $error("bit index beyond one byte");

    // Failure flag is raised only out of the acknowledge poll
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.fail_flag) |-> $past(state_reg.phase) == PH_WA_POLL)
        else $error("ack failure raised outside the poll phase");

    // State moves only when a beat is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(state_reg))
        else $error("engine state changed without a beat");

endmodule

`default_nettype wire
